// ===== src/sdd_pkg.sv =====
// Shared types, codes and the size-class mapping for the slab defrag decision block.
package sdd_pkg;

    localparam int NW = 9;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_USAGE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_ZERO_CNT  = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    localparam logic [0:0] CFG_BIN_COUNT = 1'd0;
    localparam logic [0:0] CFG_THRESHOLD = 1'd1;

    localparam logic [6:0]  BIN_COUNT_RST = 7'd36;
    localparam logic [9:0]  THRESHOLD_RST = 10'd125;
    localparam logic [31:0] PERMILLE      = 32'd1000;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } alu_mode_t;

    typedef struct packed {
        logic      start;
        alu_mode_t mode;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_U_RD,
        S_U_MUL1,
        S_U_MUL2,
        S_Q_DIV,
        S_Q_RD,
        S_Q_MUL1,
        S_Q_MUL2,
        S_Q_MUL3,
        S_Q_MUL4,
        S_DONE
    } state_t;

    function automatic logic [NW-1:0] size_to_class(input logic [31:0] sz);
        logic [31:0] szm;
        logic [5:0]  p;
        logic [32:0] pow;
        logic [32:0] diff;
        logic [32:0] q;
        logic [8:0]  res;
        szm = sz - 32'd1;
        p   = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (szm[i])
                p = 6'(i + 1);
        end
        pow  = 33'd1 << p;
        diff = pow - {1'b0, sz};
        q    = diff >> (p - 6'd3);
        if (sz <= 32'd64)
            res = 9'(sz >> 3) - 9'd1;
        else
            res = {1'b0, p, 2'b00} - 9'd17 - q[8:0];
        return res;
    endfunction

endpackage

// ===== src/sdd_alu.sv =====
// Shared shift-add multiplier and restoring divider stepped one bit per cycle.
module sdd_alu
    import sdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_req_t    req,
    input  logic [63:0] a,
    input  logic [31:0] b,
    output alu_rsp_t    rsp,
    output logic [63:0] result
);

    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    alu_mode_t   mode_reg, mode_next;
    logic [16:0] rem_sh;
    logic [16:0] rem_new;
    logic        qbit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= ALU_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
    end

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        mode_next   = mode_reg;
        rem_sh      = {acc_reg[15:0], mplier_reg[31]};
        qbit        = (rem_sh >= {1'b0, mcand_reg[15:0]});
        rem_new     = qbit ? rem_sh - {1'b0, mcand_reg[15:0]} : rem_sh;
        if (req.start)
        begin
            busy_next = 1'b1;
            mode_next = req.mode;
            acc_next  = 64'd0;
            cnt_next  = 5'd0;
            if (req.mode == ALU_DIV)
            begin
                mcand_next  = {48'd0, b[15:0]};
                mplier_next = a[31:0];
            end
            else
            begin
                mcand_next  = a;
                mplier_next = b;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == ALU_MUL)
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (mplier_reg[31:1] == 31'd0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                acc_next    = {47'd0, rem_new};
                mplier_next = {mplier_reg[30:0], qbit};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = (mode_reg == ALU_DIV) ? {32'd0, mplier_reg} : acc_reg;

endmodule

// ===== src/slab_defrag_decision.sv =====
// Top level: class tables, sequencer and result register of the slab defrag decision block.
//
// Input channel: in_valid / in_stall with one field port each; an item is taken
// when in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall, one result per item. Configuration: cfg_valid / cfg_ready with
// cfg_index (0 bin_count, 1 threshold_permille) and cfg_data; cfg_ready is
// always high and writes belong to idle periods.
// An item is worked in turn: a geometry load writes its entry; a usage update
// reads the class and runs two multiplies; a query divides and may be rejected
// before or after the divide, and a full decision runs four more multiplies.
// Each multiply steps through the bits of its multiplier and the divide through
// its quotient bits, all on the one shared shift-add unit, which sets the rate.
// in_stall stays high from acceptance until its result enters the output register.
// Reset clears the usage valid bits, the fragmentation total and loads
// bin_count 36 and threshold_permille 125. While out_stall holds a result,
// the next item may be taken and worked; it then waits for the register.
module slab_defrag_decision
    import sdd_pkg::*;
#(
    parameter int MAX_CLASSES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [5:0]  class_sel,
    input  logic [19:0] region_size,
    input  logic [15:0] regions_per_slab,
    input  logic [31:0] used_regions,
    input  logic [31:0] slab_total,
    input  logic [31:0] nonfull_slab_total,
    input  logic        start_sweep,
    input  logic [15:0] slab_free_count,
    input  logic [15:0] slab_region_count,
    input  logic [31:0] slab_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        should_move,
    output logic [63:0] fragment_bytes,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int AW = $clog2(MAX_CLASSES);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_CLASSES);

    state_t      state_reg, state_next;
    logic [1:0]  op_reg;
    logic [5:0]  idx_reg;
    logic [19:0] rsize_reg;
    logic [15:0] rps_reg;
    logic [31:0] used_reg, slabs_reg, nonfull_reg;
    logic        sweep_reg;
    logic [15:0] nfree_reg, count_reg;
    logic [31:0] len_reg;

    logic [6:0]  bin_count_reg;
    logic [9:0]  thr_reg;
    logic [63:0] total_reg, total_next;
    logic [31:0] bsz_reg, bsz_next;
    logic [31:0] afn_reg, afn_next;
    logic [63:0] lhs_reg, lhs_next;
    logic [1:0]  status_reg, status_next;
    logic        move_reg, move_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_move_reg;
    logic [63:0] out_frag_reg;
    logic [1:0]  out_status_reg;

    logic [35:0] geo_mem [MAX_CLASSES];
    logic [95:0] use_mem [MAX_CLASSES];
    logic        vld_reg [MAX_CLASSES];
    logic [35:0] geo_q;
    logic [95:0] use_q;
    logic        vld_q;

    logic          rd_en, geo_we, use_we, accept, load_out;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [NW-1:0] nclass, idx9, last9, cls_map;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;
    logic [63:0]   alu_a, alu_result;
    logic [31:0]   alu_b;

    logic [19:0] g_size;
    logic [15:0] g_regs, alloced;
    logic [31:0] u_used, u_slabs, u_nonfull, full_cnt, afn_calc;
    logic [63:0] unused;

    sdd_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign nclass  = ({2'b00, bin_count_reg} < MAX_N) ? {2'b00, bin_count_reg} : MAX_N;
    assign idx9    = {3'b000, idx_reg};
    assign last9   = nclass - NW'(1);
    assign wr_addr = idx9[AW-1:0];
    assign cls_map = size_to_class(bsz_reg);

    assign g_size    = geo_q[35:16];
    assign g_regs    = geo_q[15:0];
    assign u_used    = vld_q ? use_q[95:64] : 32'd0;
    assign u_slabs   = vld_q ? use_q[63:32] : 32'd0;
    assign u_nonfull = vld_q ? use_q[31:0]  : 32'd0;
    assign alloced   = (g_regs > nfree_reg) ? g_regs - nfree_reg : 16'd0;
    assign full_cnt  = (u_slabs > u_nonfull) ? u_slabs - u_nonfull : 32'd0;
    assign afn_calc  = ({32'd0, u_used} > alu_result) ? u_used - alu_result[31:0] : 32'd0;
    assign unused    = alu_result - {32'd0, used_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bin_count_reg <= BIN_COUNT_RST;
            thr_reg       <= THRESHOLD_RST;
            total_reg     <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BIN_COUNT: bin_count_reg <= cfg_data[6:0];
                    CFG_THRESHOLD: thr_reg       <= cfg_data;
                    default:       bin_count_reg <= bin_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= operation;
            idx_reg     <= class_sel;
            rsize_reg   <= region_size;
            rps_reg     <= regions_per_slab;
            used_reg    <= used_regions;
            slabs_reg   <= slab_total;
            nonfull_reg <= nonfull_slab_total;
            sweep_reg   <= start_sweep;
            nfree_reg   <= slab_free_count;
            count_reg   <= slab_region_count;
            len_reg     <= slab_length;
        end
        bsz_reg    <= bsz_next;
        afn_reg    <= afn_next;
        lhs_reg    <= lhs_next;
        status_reg <= status_next;
        move_reg   <= move_next;
        if (load_out)
        begin
            out_move_reg   <= move_reg;
            out_frag_reg   <= total_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (geo_we)
            geo_mem[wr_addr] <= {rsize_reg, rps_reg};
        if (use_we)
            use_mem[wr_addr] <= {used_reg, slabs_reg, nonfull_reg};
        if (rd_en)
        begin
            geo_q <= geo_mem[rd_addr];
            use_q <= use_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
                vld_reg[i] <= 1'b0;
            vld_q <= 1'b0;
        end
        else
        begin
            if (use_we)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                vld_q <= vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        bsz_next       = bsz_reg;
        afn_next       = afn_reg;
        lhs_next       = lhs_reg;
        status_next    = status_reg;
        move_next      = move_reg;
        rd_en          = 1'b0;
        rd_addr        = idx9[AW-1:0];
        geo_we         = 1'b0;
        use_we         = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.mode   = ALU_MUL;
        alu_a          = 64'd0;
        alu_b          = 32'd0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    move_next   = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (idx9 >= nclass)
                            status_next = ST_BAD_INDEX;
                        else
                            geo_we = 1'b1;
                    end
                    OP_USAGE:
                    begin
                        if (idx9 >= nclass)
                            status_next = ST_BAD_INDEX;
                        else
                        begin
                            use_we     = 1'b1;
                            rd_en      = 1'b1;
                            state_next = S_U_RD;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (nclass == NW'(0))
                            status_next = ST_BAD_INDEX;
                        else if (count_reg == 16'd0)
                            status_next = ST_ZERO_CNT;
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = last9[AW-1:0];
                            alu_req.start = 1'b1;
                            alu_req.mode  = ALU_DIV;
                            alu_a         = {32'd0, len_reg};
                            alu_b         = {16'd0, count_reg};
                            state_next    = S_Q_DIV;
                        end
                    end
                    default: status_next = ST_OK;
                endcase
            end
            S_U_RD:
            begin
                alu_req.start = 1'b1;
                alu_a         = {32'd0, slabs_reg};
                alu_b         = {16'd0, g_regs};
                state_next    = S_U_MUL1;
            end
            S_U_MUL1:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_a         = unused;
                    alu_b         = {12'd0, g_size};
                    state_next    = S_U_MUL2;
                end
            end
            S_U_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    total_next = (sweep_reg ? 64'd0 : total_reg) + alu_result;
                    state_next = S_DONE;
                end
            end
            S_Q_DIV:
            begin
                if (alu_rsp.done)
                begin
                    bsz_next   = alu_result[31:0];
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                if (bsz_reg > {12'd0, g_size})
                    state_next = S_DONE;
                else if (bsz_reg < 32'd8)
                begin
                    status_next = ST_MISMATCH;
                    state_next  = S_DONE;
                end
                else if (cls_map >= nclass)
                begin
                    status_next = ST_BAD_INDEX;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cls_map[AW-1:0];
                    state_next = S_Q_MUL1;
                end
            end
            S_Q_MUL1:
            begin
                if (!alu_rsp.busy && !alu_rsp.done)
                begin
                    if (bsz_reg != {12'd0, g_size})
                    begin
                        status_next = ST_MISMATCH;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        alu_req.start = 1'b1;
                        alu_a         = {32'd0, full_cnt};
                        alu_b         = {16'd0, g_regs};
                        state_next    = S_Q_MUL2;
                    end
                end
            end
            S_Q_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    afn_next      = afn_calc;
                    alu_req.start = 1'b1;
                    alu_a         = {32'd0, u_nonfull};
                    alu_b         = {16'd0, alloced};
                    state_next    = S_Q_MUL3;
                end
            end
            S_Q_MUL3:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_a         = alu_result;
                    alu_b         = PERMILLE;
                    state_next    = S_Q_MUL4;
                end
            end
            S_Q_MUL4:
            begin
                if (alu_rsp.done)
                begin
                    lhs_next      = alu_result;
                    alu_req.start = 1'b1;
                    alu_a         = {32'd0, afn_reg};
                    alu_b         = PERMILLE + {22'd0, thr_reg};
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (op_reg == OP_QUERY && status_reg == ST_OK && alu_rsp.busy)
                    state_next = S_DONE;
                else if (op_reg == OP_QUERY && status_reg == ST_OK && alu_rsp.done
                         && g_size == bsz_reg[19:0] && bsz_reg <= {12'd0, g_size})
                begin
                    move_next  = !(g_regs == alloced || u_nonfull < 32'd2
                                   || lhs_reg > alu_result);
                    state_next = S_DONE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign should_move    = out_move_reg;
    assign fragment_bytes = out_frag_reg;
    assign status         = out_status_reg;

endmodule

// ===== src/sdd_checker.sv =====
// Port-level checker for the slab defrag decision block and its bind.
module sdd_checker
    import sdd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        should_move,
    input logic [63:0] fragment_bytes,
    input logic [1:0]  status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fragment_bytes))
        else $error("stalled item changed");

    a_nomove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !should_move)
        else $error("move set on error status");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("not busy after accepting an item");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("item appeared with no work in progress");

endmodule

bind slab_defrag_decision sdd_checker u_sdd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .should_move    (should_move),
    .fragment_bytes (fragment_bytes),
    .status         (status)
);

// ===== tb/tb_slab_defrag_decision.sv =====
// Testbench for slab_defrag_decision: directed and random items checked against a built-in predictor.
module tb_slab_defrag_decision;
    import sdd_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  idx;
        logic [19:0] rsize;
        logic [15:0] rps;
        logic [31:0] used;
        logic [31:0] slabs;
        logic [31:0] nonfull;
        logic        sweep;
        logic [15:0] nfree;
        logic [15:0] rcount;
        logic [31:0] len;
    } slab_item_t;

    typedef struct {
        logic        move;
        logic [63:0] frag;
        logic [1:0]  st;
    } hint_t;

    localparam int CLASSES   = 64;
    localparam int STALL_MAX = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [5:0]  class_sel = '0;
    logic [19:0] region_size = '0;
    logic [15:0] regions_per_slab = '0;
    logic [31:0] used_regions = '0;
    logic [31:0] slab_total = '0;
    logic [31:0] nonfull_slab_total = '0;
    logic        start_sweep = 1'b0;
    logic [15:0] slab_free_count = '0;
    logic [15:0] slab_region_count = '0;
    logic [31:0] slab_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic        should_move;
    logic [63:0] fragment_bytes;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    logic [19:0] geo_size [CLASSES];
    logic [15:0] geo_regions [CLASSES];
    logic [31:0] use_regions [CLASSES];
    logic [31:0] use_slabs [CLASSES];
    logic [31:0] use_nonfull [CLASSES];
    logic [63:0] frag_total;
    logic [6:0]  bins_cfg;
    logic [9:0]  thresh_cfg;

    hint_t pending_hints[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    hold_off = 1'b0;
    bit    quiet = 1'b0;
    int    send_gap_max = 9;

    slab_defrag_decision dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned live_classes();
        return (bins_cfg < CLASSES) ? bins_cfg : CLASSES;
    endfunction

    function automatic longint unsigned class_index(longint unsigned sz);
        longint unsigned v;
        longint unsigned q;
        int unsigned     p;
        if (sz <= 64)
            return sz / 8 - 1;
        v = sz - 1;
        p = 0;
        while (v != 0)
        begin
            p++;
            v >>= 1;
        end
        q = ((64'd1 << p) - sz) >> (p - 3);
        return 4 * p - 17 - q;
    endfunction

    function automatic logic [19:0] canonical_size(int unsigned c);
        int unsigned     g;
        longint unsigned s;
        if (c < 8)
            return 20'(8 * (c + 1));
        g = c - 8;
        s = (64'd1 << (7 + g / 4)) - (3 - g % 4) * (64'd1 << (4 + g / 4));
        return (s > 64'hFFFFF) ? 20'hFFFFF : 20'(s);
    endfunction

    function automatic hint_t predict_hint(slab_item_t it);
        hint_t           r;
        int unsigned     n;
        longint unsigned bsz, c, nregs, nf, alloced, full, anf, lhs, rhs;
        n = live_classes();
        r.move = 1'b0;
        r.st = ST_OK;
        if (it.op == OP_LOAD)
        begin
            if (it.idx >= n)
                r.st = ST_BAD_INDEX;
            else
            begin
                geo_size[it.idx] = it.rsize;
                geo_regions[it.idx] = it.rps;
            end
        end
        else if (it.op == OP_USAGE)
        begin
            if (it.idx >= n)
                r.st = ST_BAD_INDEX;
            else
            begin
                use_regions[it.idx] = it.used;
                use_slabs[it.idx] = it.slabs;
                use_nonfull[it.idx] = it.nonfull;
                if (it.sweep)
                    frag_total = '0;
                frag_total += (64'(geo_regions[it.idx]) * it.slabs - 64'(it.used))
                              * 64'(geo_size[it.idx]);
            end
        end
        else if (it.op == OP_QUERY)
        begin
            if (n == 0)
                r.st = ST_BAD_INDEX;
            else if (it.rcount == 0)
                r.st = ST_ZERO_CNT;
            else
            begin
                bsz = 64'(it.len) / 64'(it.rcount);
                if (bsz > geo_size[n - 1])
                    r.st = ST_OK;
                else if (bsz < 8)
                    r.st = ST_MISMATCH;
                else
                begin
                    c = class_index(bsz);
                    if (c >= n)
                        r.st = ST_BAD_INDEX;
                    else if (bsz != geo_size[c])
                        r.st = ST_MISMATCH;
                    else
                    begin
                        nregs = geo_regions[c];
                        nf = use_nonfull[c];
                        alloced = (nregs > it.nfree) ? nregs - it.nfree : 0;
                        full = (use_slabs[c] > nf) ? use_slabs[c] - nf : 0;
                        anf = (use_regions[c] > full * nregs) ? use_regions[c] - full * nregs
                                                              : 0;
                        lhs = 1000 * alloced * nf;
                        rhs = (1000 + thresh_cfg) * anf;
                        r.move = !(nregs == alloced || nf < 2 || lhs > rhs);
                    end
                end
            end
        end
        r.frag = frag_total;
        return r;
    endfunction

    task automatic send_item(slab_item_t it);
        int gap;
        in_valid <= 1'b1;
        operation <= it.op;
        class_sel <= it.idx;
        region_size <= it.rsize;
        regions_per_slab <= it.rps;
        used_regions <= it.used;
        slab_total <= it.slabs;
        nonfull_slab_total <= it.nonfull;
        start_sweep <= it.sweep;
        slab_free_count <= it.nfree;
        slab_region_count <= it.rcount;
        slab_length <= it.len;
        do
            @(posedge clk);
        while (in_stall);
        pending_hints.push_back(predict_hint(it));
        gap = quiet ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_hints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] ridx, logic [9:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ridx == CFG_BIN_COUNT)
            bins_cfg = val[6:0];
        else
            thresh_cfg = val;
    endtask

    function automatic slab_item_t blank_item(logic [1:0] op);
        slab_item_t it;
        it = '{op: op, default: '0};
        it.idx = 6'($urandom);
        it.rsize = 20'($urandom);
        it.rps = 16'($urandom);
        it.used = $urandom;
        it.slabs = $urandom;
        it.nonfull = $urandom;
        it.sweep = 1'($urandom);
        it.nfree = 16'($urandom);
        it.rcount = 16'($urandom);
        it.len = $urandom;
        return it;
    endfunction

    function automatic slab_item_t load_item(int unsigned c, bit odd_size);
        slab_item_t it;
        it = blank_item(OP_LOAD);
        it.idx = 6'(c);
        it.rsize = odd_size ? 20'($urandom) : canonical_size(c);
        it.rps = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
        return it;
    endfunction

    function automatic slab_item_t usage_item(int unsigned c);
        slab_item_t      it;
        longint unsigned lo, hi;
        it = blank_item(OP_USAGE);
        it.idx = 6'(c);
        it.sweep = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 7) == 0)
            return it;
        it.slabs = $urandom_range(0, 40);
        it.nonfull = $urandom_range(0, it.slabs);
        lo = 64'(it.slabs - it.nonfull) * geo_regions[c];
        hi = 64'(it.slabs) * geo_regions[c];
        it.used = 32'(lo + $urandom_range(0, 32'(hi - lo)));
        return it;
    endfunction

    function automatic slab_item_t query_item(int unsigned c);
        slab_item_t      it;
        longint unsigned sz, cap;
        it = blank_item(OP_QUERY);
        sz = geo_size[c];
        if (sz < 8 || $urandom_range(0, 7) == 0)
            return it;
        cap = 64'hFFFF_FFFF / (sz + 1);
        if (cap > 65535)
            cap = 65535;
        if ($urandom_range(0, 1) && cap > 64)
            cap = 64;
        it.rcount = 16'($urandom_range(1, 32'(cap)));
        it.len = 32'(sz * it.rcount + $urandom_range(0, it.rcount - 1));
        it.nfree = 16'($urandom_range(0, geo_regions[c] + 1));
        return it;
    endfunction

    function automatic slab_item_t random_item();
        int unsigned n;
        int unsigned pick;
        n = live_classes();
        pick = $urandom_range(0, 19);
        if (n == 0 || pick == 0)
            return blank_item(2'($urandom));
        if (pick < 3)
            return load_item($urandom_range(0, n - 1), $urandom_range(0, 5) == 0);
        if (pick < 9)
            return usage_item($urandom_range(0, n - 1));
        return query_item($urandom_range(0, n - 1));
    endfunction

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_class_setup();
        write_reg(CFG_BIN_COUNT, 10'd64);
        for (int c = 0; c < CLASSES; c++)
            send_item(load_item(c, c == CLASSES - 1));
    endtask

    task automatic test_directed();
        slab_item_t it;
        it = usage_item(3);
        it.sweep = 1'b1;
        send_item(it);
        it = blank_item(OP_USAGE);
        it.idx = 6'd5;
        it.used = '1;
        it.slabs = '1;
        it.nonfull = '0;
        send_item(it);
        it = blank_item(OP_USAGE);
        it.idx = 6'd0;
        it.used = '0;
        it.slabs = '0;
        it.nonfull = '1;
        it.sweep = 1'b0;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = '0;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = 16'd1;
        it.len = '1;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = '1;
        it.len = 32'd7 * 32'hFFFF;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = 16'd1;
        it.len = 32'd9;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = 16'd1;
        it.len = 32'd1048576;
        send_item(it);
        it = blank_item(OP_QUERY);
        it.rcount = 16'd1;
        it.len = 32'd8;
        it.nfree = '1;
        send_item(it);
        for (int k = 0; k < 4; k++)
        begin
            it = usage_item(10);
            send_item(it);
            it = query_item(10);
            it.nfree = (k == 0) ? 16'd0 : 16'($urandom_range(0, 2));
            send_item(it);
        end
        send_item(blank_item(2'd3));
        write_reg(CFG_BIN_COUNT, 10'd20);
        it = blank_item(OP_LOAD);
        it.idx = 6'd63;
        send_item(it);
        it = blank_item(OP_USAGE);
        it.idx = 6'd20;
        send_item(it);
        send_item(query_item(30));
        write_reg(CFG_BIN_COUNT, 10'd0);
        send_item(blank_item(OP_QUERY));
        send_item(blank_item(OP_LOAD));
        send_item(blank_item(OP_USAGE));
    endtask

    task automatic test_backpressure();
        write_reg(CFG_BIN_COUNT, 10'd64);
        fork
            begin
                hold_off <= 1'b1;
                repeat (600) @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                quiet = 1'b1;
                run_random(12);
                quiet = 1'b0;
            end
        join
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_THRESHOLD, 10'd0);
        run_random(60);
        write_reg(CFG_THRESHOLD, 10'd1000);
        write_reg(CFG_BIN_COUNT, 10'd127);
        run_random(60);
        write_reg(CFG_THRESHOLD, 10'h3FF);
        write_reg(CFG_BIN_COUNT, 10'd1);
        run_random(20);
        write_reg(CFG_BIN_COUNT, 10'd36);
        write_reg(CFG_THRESHOLD, 10'd125);
        quiet = 1'b1;
        run_random(40);
        quiet = 1'b0;
    endtask

    task automatic test_random();
        write_reg(CFG_BIN_COUNT, 10'd64);
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_THRESHOLD, 10'($urandom_range(0, 1000)));
            send_gap_max = (k == 2) ? 0 : 9;
            run_random(30);
        end
        send_gap_max = 9;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    int hold_left = 0;

    always @(posedge clk)
    begin
        hint_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hints.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                want = pending_hints.pop_front();
                if (should_move !== want.move)
                begin
                    $error("should_move exp %0d got %0d", want.move, should_move);
                    errors++;
                end
                if (fragment_bytes !== want.frag)
                begin
                    $error("fragment_bytes exp %0h got %0h", want.frag, fragment_bytes);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status exp %0d got %0d", want.st, status);
                    errors++;
                end
            end
            hold_left = quiet ? 0 : $urandom_range(0, 9);
        end
        else if (hold_left > 0)
            hold_left--;
        out_stall <= !rst_n || hold_off || hold_left != 0;
    end

    initial
    begin
        bins_cfg = BIN_COUNT_RST;
        thresh_cfg = THRESHOLD_RST;
        frag_total = '0;
        for (int c = 0; c < CLASSES; c++)
        begin
            geo_size[c] = '0;
            geo_regions[c] = '0;
            use_regions[c] = '0;
            use_slabs[c] = '0;
            use_nonfull[c] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_class_setup();
        test_directed();
        test_backpressure();
        test_config_sweep();
        test_random();
        drain();
        repeat (150) @(posedge clk);
        if (errors == 0 && pending_hints.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
